// ===== rtl/mts_pkg.sv =====
// Package for the melody tone sequencer: register map, song and reload tables, shared types.
`timescale 1ns / 1ps

package mts_pkg;

  localparam int unsigned SONG_NOTES   = 27;
  localparam int unsigned FREQ_ENTRIES = 28;
  localparam int unsigned SONG_ROM_LEN = 81;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned ADDR_W       = 4;
  localparam int unsigned OCTAVE_STEP  = 7;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_CYCLES_PER_MS = 2'd0;
  localparam logic [1:0] REG_MS_PER_UNIT   = 2'd1;
  localparam logic [1:0] REG_MS_PER_SECOND = 2'd2;
  localparam logic [1:0] REG_SLEEP_SECONDS = 2'd3;

  localparam logic [15:0] RST_CYCLES_PER_MS = 16'd1000;
  localparam logic [7:0]  RST_MS_PER_UNIT   = 8'd250;
  localparam logic [15:0] RST_MS_PER_SECOND = 16'd1000;
  localparam logic [7:0]  RST_SLEEP_SECONDS = 8'd10;

  // pitch, octave, duration per note
  localparam logic [7:0] SONG_ROM [SONG_ROM_LEN] = '{
    8'd5, 8'd2, 8'd1,  8'd5, 8'd2, 8'd1,  8'd6, 8'd2, 8'd2,  8'd5, 8'd2, 8'd2,
    8'd1, 8'd3, 8'd2,  8'd7, 8'd2, 8'd2,  8'd0, 8'd0, 8'd2,  8'd5, 8'd2, 8'd1,
    8'd5, 8'd2, 8'd1,  8'd6, 8'd2, 8'd2,  8'd5, 8'd2, 8'd2,  8'd2, 8'd3, 8'd2,
    8'd1, 8'd3, 8'd4,  8'd5, 8'd2, 8'd1,  8'd5, 8'd2, 8'd1,  8'd5, 8'd3, 8'd2,
    8'd3, 8'd3, 8'd2,  8'd1, 8'd3, 8'd2,  8'd7, 8'd2, 8'd2,  8'd6, 8'd2, 8'd4,
    8'd0, 8'd0, 8'd2,  8'd4, 8'd3, 8'd1,  8'd4, 8'd3, 8'd1,  8'd3, 8'd3, 8'd2,
    8'd1, 8'd3, 8'd2,  8'd2, 8'd3, 8'd2,  8'd1, 8'd3, 8'd4
  };

  localparam logic [15:0] FREQ_ROM [FREQ_ENTRIES] = '{
    16'hF242, 16'hF3C1, 16'hF517, 16'hF5B6, 16'hF6D0, 16'hF7D1, 16'hF8B6,
    16'hF921, 16'hF9E1, 16'hFA8C, 16'hFAD8, 16'hFB68, 16'hFBE9, 16'hFC5B,
    16'hFC8F, 16'hFCEE, 16'hFD44, 16'hFD6B, 16'hFDB4, 16'hFDF4, 16'hFE2D,
    16'hFE47, 16'hFE77, 16'hFEA2, 16'hFEB6, 16'hFEDA, 16'hFEFA, 16'hFF16
  };

  // Decoded note handed from the note lookup to the sequencer
  typedef struct packed {
    logic             rest;
    logic [15:0]      reload;
    logic [7:0]       length;
    logic [POS_W-1:0] next_pos;
  } note_t;

endpackage

// ===== rtl/mts_note_rom.sv =====
// Note lookup: song table read at a position, pitch/octave mapped to a timer reload.
`timescale 1ns / 1ps

module mts_note_rom (
  input  logic [mts_pkg::POS_W-1:0] pos,
  output mts_pkg::note_t            note
);

  logic [mts_pkg::POS_W-1:0] p;
  logic [6:0]                base;
  logic [7:0]                pitch;
  logic [7:0]                octave;
  logic [10:0]               k;
  logic [10:0]               km1;
  logic                      in_table;
  logic [4:0]                fidx;
  logic [mts_pkg::POS_W-1:0] p_inc;

  always_comb begin
    p = (32'(pos) >= mts_pkg::SONG_NOTES) ? '0 : pos;
    base = 7'(7'(p) * 7'd3);
    pitch  = mts_pkg::SONG_ROM[base];
    octave = mts_pkg::SONG_ROM[7'(base + 7'd1)];
    k   = 11'(pitch) + 11'(octave) * 11'(mts_pkg::OCTAVE_STEP);
    km1 = k - 11'd1;
    in_table = (pitch != 8'd0) && (32'(km1) < mts_pkg::FREQ_ENTRIES);
    fidx = in_table ? km1[4:0] : 5'd0;
    p_inc = p + 1'b1;

    note.rest     = !in_table;
    note.reload   = mts_pkg::FREQ_ROM[fidx];
    note.length   = mts_pkg::SONG_ROM[7'(base + 7'd2)];
    note.next_pos = (32'(p_inc) >= mts_pkg::SONG_NOTES) ? '0 : p_inc;
  end

endmodule

// ===== rtl/melody_tone_sequencer_core.sv =====
// Melody tone sequencer top level: handshakes, APB registers and the per-cycle sequencer state.
`timescale 1ns / 1ps

// Channel   Direction  Signals
// in_       request    in_valid/in_ready, in_cycle_passes, in_wake
// out_      result     out_valid/out_ready, out_speaker_level, out_sleeping, out_note_number
// APB       config     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One request per clock while the output is not stalled: all state advances in the cycle a
// request is taken and the result lands in the output register the next cycle. The critical
// path is the divider/beat compare chain feeding the song and reload table lookup.
// Reset (rst_n low, synchronous) restores register defaults and rewinds the song.
// A stalled result holds in the output register; a new request is taken as it drains.

module melody_tone_sequencer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cycle_passes,
  input  logic                       in_wake,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_speaker_level,
  output logic                       out_sleeping,
  output logic [4:0]                 out_note_number,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mts_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [15:0] cycles_per_ms_r, ms_per_second_r;
  logic [7:0]  ms_per_unit_r, sleep_seconds_r;

  logic [15:0] cycle_div_r, tone_timer_r, tone_reload_r, ms_count_r;
  logic [7:0]  second_count_r, unit_ms_r, unit_count_r, note_length_r;
  logic [mts_pkg::POS_W-1:0] song_pos_r;
  logic        wave_r, silent_r, asleep_r;

  logic [15:0] cycle_div_nxt, tone_timer_nxt, tone_reload_nxt, ms_count_nxt;
  logic [7:0]  second_count_nxt, unit_ms_nxt, unit_count_nxt, note_length_nxt;
  logic [mts_pkg::POS_W-1:0] song_pos_nxt;
  logic        wave_nxt, silent_nxt, asleep_nxt;

  logic        out_valid_r, speaker_r, sleeping_r;
  logic [4:0]  note_num_r;

  logic        accept;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  logic [15:0] ms_inc, div_inc;
  logic [7:0]  sec_inc, unit_ms_inc, unit_inc;
  logic        sleep_due;
  logic [mts_pkg::POS_W-1:0] fetch_pos;
  mts_pkg::note_t note;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      mts_pkg::REG_CYCLES_PER_MS: prdata = {16'd0, cycles_per_ms_r};
      mts_pkg::REG_MS_PER_UNIT:   prdata = {24'd0, ms_per_unit_r};
      mts_pkg::REG_MS_PER_SECOND: prdata = {16'd0, ms_per_second_r};
      mts_pkg::REG_SLEEP_SECONDS: prdata = {24'd0, sleep_seconds_r};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycles_per_ms_r <= mts_pkg::RST_CYCLES_PER_MS;
      ms_per_unit_r   <= mts_pkg::RST_MS_PER_UNIT;
      ms_per_second_r <= mts_pkg::RST_MS_PER_SECOND;
      sleep_seconds_r <= mts_pkg::RST_SLEEP_SECONDS;
    end else if (cfg_wr) begin
      case (reg_idx)
        mts_pkg::REG_CYCLES_PER_MS: cycles_per_ms_r <= pwdata[15:0];
        mts_pkg::REG_MS_PER_UNIT:   ms_per_unit_r   <= pwdata[7:0];
        mts_pkg::REG_MS_PER_SECOND: ms_per_second_r <= pwdata[15:0];
        mts_pkg::REG_SLEEP_SECONDS: sleep_seconds_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Counter increments and the sleep decision, which rewinds the song before any fetch
  assign div_inc     = cycle_div_r + 16'd1;
  assign ms_inc      = ms_count_r + 16'd1;
  assign sec_inc     = second_count_r + 8'd1;
  assign unit_ms_inc = unit_ms_r + 8'd1;
  assign unit_inc    = unit_count_r + 8'd1;
  assign sleep_due   = (ms_inc >= ms_per_second_r) && (sec_inc >= sleep_seconds_r);
  assign fetch_pos   = sleep_due ? '0 : song_pos_r;

  mts_note_rom u_note_rom (
    .pos  (fetch_pos),
    .note (note)
  );

  always_comb begin
    cycle_div_nxt    = cycle_div_r;
    tone_timer_nxt   = tone_timer_r;
    tone_reload_nxt  = tone_reload_r;
    ms_count_nxt     = ms_count_r;
    second_count_nxt = second_count_r;
    unit_ms_nxt      = unit_ms_r;
    unit_count_nxt   = unit_count_r;
    note_length_nxt  = note_length_r;
    song_pos_nxt     = song_pos_r;
    wave_nxt         = wave_r;
    silent_nxt       = silent_r;
    asleep_nxt       = asleep_r;

    if (asleep_r && in_wake) begin
      asleep_nxt = 1'b0;
      if (silent_r) wave_nxt = 1'b0;
    end

    if (!asleep_nxt && in_cycle_passes) begin
      if (tone_timer_r == 16'hFFFF) begin
        tone_timer_nxt = tone_reload_r;
        if (!silent_r) wave_nxt = !wave_nxt;
      end else begin
        tone_timer_nxt = tone_timer_r + 16'd1;
      end

      cycle_div_nxt = div_inc;
      if (div_inc >= cycles_per_ms_r) begin
        cycle_div_nxt = 16'd0;
        // millisecond tick
        ms_count_nxt = ms_inc;
        if (ms_inc >= ms_per_second_r) begin
          ms_count_nxt     = 16'd0;
          second_count_nxt = sleep_due ? 8'd0 : sec_inc;
          if (sleep_due) song_pos_nxt = '0;
        end
        unit_ms_nxt = unit_ms_inc;
        if (unit_ms_inc >= ms_per_unit_r) begin
          unit_ms_nxt    = 8'd0;
          unit_count_nxt = unit_inc;
          if (unit_inc >= note_length_r) begin
            unit_count_nxt  = 8'd0;
            note_length_nxt = note.length;
            song_pos_nxt    = note.next_pos;
            if (note.rest) begin
              silent_nxt = 1'b1;
              wave_nxt   = 1'b0;
            end else begin
              silent_nxt      = 1'b0;
              tone_reload_nxt = note.reload;
            end
          end
        end
        if (sleep_due) begin
          wave_nxt   = 1'b1;
          asleep_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_div_r    <= 16'd0;
      tone_timer_r   <= 16'd0;
      tone_reload_r  <= 16'd0;
      ms_count_r     <= 16'd0;
      second_count_r <= 8'd0;
      unit_ms_r      <= 8'd0;
      unit_count_r   <= 8'd0;
      note_length_r  <= 8'd1;
      song_pos_r     <= '0;
      wave_r         <= 1'b0;
      silent_r       <= 1'b0;
      asleep_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        cycle_div_r    <= cycle_div_nxt;
        tone_timer_r   <= tone_timer_nxt;
        tone_reload_r  <= tone_reload_nxt;
        ms_count_r     <= ms_count_nxt;
        second_count_r <= second_count_nxt;
        unit_ms_r      <= unit_ms_nxt;
        unit_count_r   <= unit_count_nxt;
        note_length_r  <= note_length_nxt;
        song_pos_r     <= song_pos_nxt;
        wave_r         <= wave_nxt;
        silent_r       <= silent_nxt;
        asleep_r       <= asleep_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: note number is the one before the next fetch position
  always_ff @(posedge clk) begin
    if (accept) begin
      speaker_r  <= wave_nxt;
      sleeping_r <= asleep_nxt;
      note_num_r <= (song_pos_nxt == '0) ? 5'(mts_pkg::SONG_NOTES - 1)
                                         : 5'(song_pos_nxt - 1'b1);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_speaker_level = speaker_r;
  assign out_sleeping      = sleeping_r;
  assign out_note_number   = note_num_r;

endmodule
